[sv/lesf_pkg.sv]
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared types and constants of the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int ADDR_W = $clog2(MAX_WIDTH);   // line buffer address
   localparam int CNT_W  = 11;                  // column / row counters, can hold the limit
   localparam int SIZE_W = 11;                  // square side
   localparam int POS_W  = 10;                  // corner coordinates
   localparam int CHAR_W = 8;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_EMPTY_CHAR    = 2'd0,
      CSR_OBSTACLE_CHAR = 2'd1,
      CSR_ROWS_IN_MAP   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              mode;
      logic [CHAR_W-1:0] cell_req;
   } req_data_type;

   typedef struct packed {
      logic [POS_W-1:0]  best_row;
      logic [POS_W-1:0]  best_col;
      logic [SIZE_W-1:0] best_size;
      logic              map_error;
   } rsp_data_type;

   // classified item, front to back
   typedef struct packed {
      logic is_eol;
      logic is_obstacle;
      logic is_foreign;
   } item_type;

   // map geometry seen by the back end
   typedef struct packed {
      logic [CNT_W-1:0] rows_target;
      logic             too_tall;
   } map_cfg_type;

   // item held in the execute stage of the back end
   typedef struct packed {
      logic             is_eol;
      logic             last;
      logic             map_err;
      logic             obstacle;
      logic             edge_cell;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } exec_type;

endpackage

[sv/lesf_front.sv]
// ----------------------------------------------------------------------------
// lesf_front
// Configuration registers and classification of incoming map items.
// ----------------------------------------------------------------------------
module lesf_front import lesf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  req_data_type      req_data,
   input  logic              q_full,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [CNT_W-1:0]  csr_wdata,
   output logic              q_push,
   output item_type          q_item,
   output map_cfg_type       map_cfg
);

   logic [CHAR_W-1:0] empty_char_ff;
   logic [CHAR_W-1:0] obstacle_char_ff;
   logic [CNT_W-1:0]  rows_ff;
   logic [CNT_W-1:0]  target;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_char_ff    <= CHAR_W'(46);
         obstacle_char_ff <= CHAR_W'(111);
         rows_ff          <= CNT_W'(1);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_EMPTY_CHAR:    empty_char_ff    <= csr_wdata[CHAR_W-1:0];
            CSR_OBSTACLE_CHAR: obstacle_char_ff <= csr_wdata[CHAR_W-1:0];
            CSR_ROWS_IN_MAP:   rows_ff          <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a zero row count means one row
   assign target               = (rows_ff == '0) ? CNT_W'(1) : rows_ff;
   assign map_cfg.rows_target  = target;
   assign map_cfg.too_tall     = (32'(target) > MAX_HEIGHT);

   // obstacle wins when both codes are equal
   assign q_push             = req_push && !q_full;
   assign q_item.is_eol      = req_data.mode;
   assign q_item.is_obstacle = (req_data.cell_req == obstacle_char_ff);
   assign q_item.is_foreign  = (req_data.cell_req != obstacle_char_ff) &&
                               (req_data.cell_req != empty_char_ff);

endmodule

[sv/lesf_queue.sv]
// ----------------------------------------------------------------------------
// lesf_queue
// Four-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module lesf_queue import lesf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     empty,
   output item_type head
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W:0]     count_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = (count_ff == (PTR_W+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[sv/lesf_back.sv]
// ----------------------------------------------------------------------------
// lesf_back
// Square-size recurrence: issue stage, line buffer, execute stage, result.
// ----------------------------------------------------------------------------
module lesf_back import lesf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  map_cfg_type  map_cfg,
   input  logic         q_empty,
   input  item_type     q_head,
   output logic         q_pop,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output rsp_data_type rsp_data
);

   localparam logic [CNT_W-1:0] COL_LIMIT = CNT_W'(MAX_WIDTH);

   // issue stage state
   logic [CNT_W-1:0]  col_ff,   col_in;
   logic [CNT_W-1:0]  row_ff,   row_in;
   logic [CNT_W-1:0]  width_ff, width_in;
   logic              err_ff,   err_in;

   // execute stage
   logic              s2_valid_ff, s2_valid_in;
   exec_type          s2_ff,       s2_in;
   logic [SIZE_W-1:0] above_ff;
   logic [SIZE_W-1:0] left_ff,  left_in;
   logic [SIZE_W-1:0] diag_ff,  diag_in;
   logic [SIZE_W-1:0] best_size_ff, best_size_in;
   logic [POS_W-1:0]  best_row_ff,  best_row_in;
   logic [POS_W-1:0]  best_col_ff,  best_col_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff;

   logic [SIZE_W-1:0] line_mem [MAX_WIDTH];

   logic              s2_hold;
   logic              take;
   logic              take_cell;
   logic              col_over;
   logic              eol_err;
   logic [CNT_W-1:0]  row_next;
   logic              row_last;
   logic              rsp_load;
   logic [SIZE_W-1:0] least;
   logic [SIZE_W-1:0] size;
   logic              mem_wr;

   // hold the final line-end item until the result register frees up
   assign s2_hold   = s2_valid_ff && s2_ff.is_eol && s2_ff.last &&
                      rsp_valid_ff && !rsp_pop;
   assign take      = !q_empty && !s2_hold;
   assign q_pop     = take;
   assign col_over  = (col_ff >= COL_LIMIT);
   assign take_cell = take && !q_head.is_eol && !col_over;
   assign row_next  = row_ff + 1'b1;
   assign row_last  = (row_next == map_cfg.rows_target);

   // issue: count columns and rows, check shape, read the line buffer
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      width_in    = width_ff;
      err_in      = err_ff;
      eol_err     = 1'b0;
      s2_valid_in = s2_hold ? s2_valid_ff : 1'b0;
      s2_in       = s2_ff;
      if (take) begin
         s2_in.is_eol    = q_head.is_eol;
         s2_in.last      = 1'b0;
         s2_in.map_err   = 1'b0;
         s2_in.obstacle  = q_head.is_obstacle;
         s2_in.edge_cell = (row_ff == '0) || (col_ff == '0);
         s2_in.row       = row_ff[POS_W-1:0];
         s2_in.col       = col_ff[POS_W-1:0];
         if (!q_head.is_eol) begin
            if (col_over) begin
               // drop cells past the width limit
               err_in = 1'b1;
            end else begin
               s2_valid_in = 1'b1;
               err_in      = err_ff || q_head.is_foreign;
               col_in      = col_ff + 1'b1;
            end
         end else begin
            s2_valid_in = 1'b1;
            if (col_ff == '0) begin
               eol_err = 1'b1;
            end else if (width_ff == '0) begin
               width_in = col_ff;
            end else if (col_ff != width_ff) begin
               eol_err = 1'b1;
            end
            s2_in.last    = row_last;
            s2_in.map_err = err_ff || eol_err || map_cfg.too_tall;
            col_in        = '0;
            if (row_last) begin
               row_in   = '0;
               width_in = '0;
               err_in   = 1'b0;
            end else begin
               row_in = row_next;
               err_in = err_ff || eol_err;
            end
         end
      end
   end

   // execute: three-way minimum, best tracking, result hand-off
   always_comb begin
      least = above_ff;
      if (left_ff < least) least = left_ff;
      if (diag_ff < least) least = diag_ff;
      if (s2_ff.obstacle)       size = '0;
      else if (s2_ff.edge_cell) size = SIZE_W'(1);
      else                      size = least + 1'b1;
   end

   assign mem_wr   = s2_valid_ff && !s2_ff.is_eol;
   assign rsp_load = s2_valid_ff && s2_ff.is_eol && s2_ff.last && !s2_hold;

   always_comb begin
      left_in      = left_ff;
      diag_in      = diag_ff;
      best_size_in = best_size_ff;
      best_row_in  = best_row_ff;
      best_col_in  = best_col_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      if (mem_wr) begin
         left_in = size;
         diag_in = above_ff;
         if (size > best_size_ff) begin
            best_size_in = size;
            best_row_in  = s2_ff.row - size[POS_W-1:0] + 1'b1;
            best_col_in  = s2_ff.col - size[POS_W-1:0] + 1'b1;
         end
      end else if (s2_valid_ff && s2_ff.is_eol && !s2_hold) begin
         left_in = '0;
         diag_in = '0;
         if (s2_ff.last) begin
            rsp_valid_in = 1'b1;
            best_size_in = '0;
            best_row_in  = '0;
            best_col_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[s2_ff.col] <= size;
      end
      if (take_cell) begin
         above_ff <= line_mem[col_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.best_row  <= best_row_ff;
         rsp_data_ff.best_col  <= best_col_ff;
         rsp_data_ff.best_size <= best_size_ff;
         rsp_data_ff.map_error <= s2_ff.map_err;
      end
      if (take) begin
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         width_ff     <= '0;
         err_ff       <= 1'b0;
         s2_valid_ff  <= 1'b0;
         left_ff      <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_row_ff  <= '0;
         best_col_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         width_ff     <= width_in;
         err_ff       <= err_in;
         s2_valid_ff  <= s2_valid_in;
         left_ff      <= left_in;
         diag_ff      <= diag_in;
         best_size_ff <= best_size_in;
         best_row_ff  <= best_row_in;
         best_col_ff  <= best_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/largest_empty_square_finder_unit.sv]
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit
// Streams a character map and reports the largest free square in it.
// ----------------------------------------------------------------------------
//
//   channel   ports                               transfer when
//   -------   ---------------------------------   -------------------------
//   request   req_push, req_full, req_data        req_push && !req_full
//   response  rsp_pop, rsp_empty, rsp_data        rsp_pop && !rsp_empty
//   csr       csr_we, csr_index, csr_wdata        csr_we
//
// One item per cycle sustained unless a waiting result stalls; the line
// buffer is read once and written once per cell, in different pipeline stages.
// A result shows on rsp_data once the last line end reaches the result register.
// Reset is synchronous; there is no clearing pass, and in a well-formed map
// only line buffer entries that the current map has written are used.
// A waiting result stalls the final line-end of the next map; later items
// collect in the four-entry queue meanwhile.
//
module largest_empty_square_finder_unit import lesf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request side
   input  logic             req_push,
   output logic             req_full,
   input  req_data_type     req_data,
   // response side
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_data_type     rsp_data,
   // configuration
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [CNT_W-1:0] csr_wdata
);

   logic        q_push;
   item_type    q_item;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   item_type    q_head;
   map_cfg_type map_cfg;

   // classify characters against the configured codes
   lesf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .q_full    (q_full),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_item    (q_item),
      .map_cfg   (map_cfg)
   );

   // decouple the front from back-end stalls
   lesf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .head      (q_head)
   );

   // run the recurrence and hold the result
   lesf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .map_cfg   (map_cfg),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full;

endmodule

[sim/largest_empty_square_finder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit_tb
// Self-checking bench for the largest empty square finder.
// Streams character maps through the request queue and compares every
// reported square with a cycle-free scan model kept in this file. A short
// scripted map set comes first, then the width and height limits, then
// random maps under random character codes and map heights. Both queues
// idle and stall at random.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_unit_tb;
   import lesf_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 12;      // drain time after the last expected square
   localparam int RANDOM_ITEMS = 1200;
   localparam int RANDOM_MAPS  = 48;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int TALL_ROWS    = 2047;    // beyond MAX_HEIGHT, all bits of the row count set
   localparam int WRAP_ROW     = 1100;    // row of the lone free cell in the tall map
   localparam int WIDE_CELLS   = 1030;    // a few cells past MAX_WIDTH

   localparam logic [CHAR_W-1:0] DOT  = 8'd46;   // '.'
   localparam logic [CHAR_W-1:0] RING = 8'd111;  // 'o'
   localparam logic [CHAR_W-1:0] EX   = 8'd120;  // 'x', neither code at reset

   // ------------------------------------------------------------------
   // DUT ports, inputs all known from time zero
   // ------------------------------------------------------------------
   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   req_data_type     req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   rsp_data_type     rsp_data;
   logic             csr_we    = 1'b0;
   logic [1:0]       csr_index = CSR_EMPTY_CHAR;
   logic [CNT_W-1:0] csr_wdata = '0;

   largest_empty_square_finder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Scan model: register copies and map state at the block's widths
   // ------------------------------------------------------------------
   logic [CHAR_W-1:0] cfg_empty;
   logic [CHAR_W-1:0] cfg_obstacle;
   logic [CNT_W-1:0]  cfg_rows;

   logic [SIZE_W-1:0] line_sizes [MAX_WIDTH];   // sizes of the row above
   logic [SIZE_W-1:0] left_sz;
   logic [SIZE_W-1:0] diag_sz;
   logic [CNT_W-1:0]  col_pos;
   logic [CNT_W-1:0]  row_pos;
   logic [CNT_W-1:0]  row_width;                 // 0 until the first non-empty line ends
   logic [SIZE_W-1:0] best_sz;
   logic [POS_W-1:0]  best_r;
   logic [POS_W-1:0]  best_c;
   bit                bad_map;

   rsp_data_type expected_squares [$];

   int items_sent     = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int push_calm      = 0;    // items left in a stretch without idling
   int pop_calm       = 0;

   function automatic void clear_scan();
      left_sz   = '0;
      diag_sz   = '0;
      col_pos   = '0;
      row_pos   = '0;
      row_width = '0;
      best_sz   = '0;
      best_r    = '0;
      best_c    = '0;
      bad_map   = 1'b0;
   endfunction

   function automatic void scan_reset();
      cfg_empty    = DOT;
      cfg_obstacle = RING;
      cfg_rows     = 11'd1;
      foreach (line_sizes[i]) line_sizes[i] = '0;
      clear_scan();
   endfunction

   // Advance the scan by one item; return 1 with the square when a map ends.
   function automatic bit scan_item(input req_data_type item, output rsp_data_type square);
      logic [SIZE_W-1:0] above;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] least;
      logic [CNT_W-1:0]  target;
      square = '0;
      if (!item.mode) begin
         // drop cells past the width limit, flag the map
         if (col_pos >= MAX_WIDTH) begin
            bad_map = 1'b1;
            col_pos = CNT_W'(MAX_WIDTH);
            return 1'b0;
         end
         if (item.cell_req != cfg_obstacle && item.cell_req != cfg_empty)
            bad_map = 1'b1;       // foreign code still scores as free
         above = line_sizes[col_pos[ADDR_W-1:0]];
         if (item.cell_req == cfg_obstacle)
            size = '0;
         else if (row_pos == 0 || col_pos == 0)
            size = 11'd1;
         else begin
            least = above;
            if (left_sz < least) least = left_sz;
            if (diag_sz < least) least = diag_sz;
            size = least + 1'b1;
         end
         if (size > best_sz) begin
            best_sz = size;
            best_r  = POS_W'(row_pos - size + 1'b1);
            best_c  = POS_W'(col_pos - size + 1'b1);
         end
         diag_sz = above;
         left_sz = size;
         line_sizes[col_pos[ADDR_W-1:0]] = size;
         col_pos = col_pos + 1'b1;
         return 1'b0;
      end
      if (col_pos == 0)
         bad_map = 1'b1;
      else if (row_width == 0)
         row_width = col_pos;
      else if (col_pos != row_width)
         bad_map = 1'b1;
      row_pos = row_pos + 1'b1;
      col_pos = '0;
      left_sz = '0;
      diag_sz = '0;
      target  = (cfg_rows == 0) ? 11'd1 : cfg_rows;
      if (row_pos != target)
         return 1'b0;
      square.best_row  = best_r;
      square.best_col  = best_c;
      square.best_size = best_sz;
      square.map_error = bad_map || (target > MAX_HEIGHT);
      clear_scan();
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // Pacing and item helpers
   // ------------------------------------------------------------------
   // Draw the wait before the next transfer; now and then run a stretch
   // with no idling at all.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   function automatic req_data_type map_char(input logic [CHAR_W-1:0] code);
      req_data_type item;
      item.mode     = 1'b0;
      item.cell_req = code;
      return item;
   endfunction

   // Line end; the code field is ignored, so fill it with noise.
   function automatic req_data_type line_end();
      req_data_type item;
      item.mode     = 1'b1;
      item.cell_req = CHAR_W'($urandom);
      return item;
   endfunction

   // Push one item and feed it to the scan model once it transfers. A typed
   // square, where given, stands in for the model's answer.
   task automatic transfer_item(input req_data_type item, input bit typed,
                                input rsp_data_type typed_square);
      int gap;
      rsp_data_type predicted;
      gap = draw_gap(push_calm);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      // hold push until the queue takes the item
      do @(posedge clock); while (req_full);
      items_sent = items_sent + 1;
      if (scan_item(item, predicted))
         expected_squares.push_back(typed ? typed_square : predicted);
   endtask

   task automatic send_item(input req_data_type item);
      transfer_item(item, 1'b0, '0);
   endtask

   // Let every expected square come out, then let the pipeline settle.
   task automatic wait_quiet();
      req_push <= 1'b0;
      while (expected_squares.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write one register; only called while the block is quiet.
   task automatic write_reg(input csr_index_type sel, input logic [CNT_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (sel)
         CSR_EMPTY_CHAR:    cfg_empty    = data[CHAR_W-1:0];
         CSR_OBSTACLE_CHAR: cfg_obstacle = data[CHAR_W-1:0];
         CSR_ROWS_IN_MAP:   cfg_rows     = data;
         default: ;
      endcase
   endtask

   // One map of the configured height: mostly well formed with random
   // obstacle density; some maps broken by ragged rows and foreign codes.
   task automatic send_map(input int height);
      int width;
      int len;
      int density;
      bit broken;
      logic [CHAR_W-1:0] pick;
      width   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      broken  = ($urandom_range(0, 4) == 0);
      density = $urandom_range(0, 60);
      for (int r = 0; r < height; r++) begin
         len = (broken && $urandom_range(0, 2) == 0) ? $urandom_range(0, width + 3) : width;
         for (int c = 0; c < len; c++) begin
            if (broken && $urandom_range(0, 15) == 0)
               pick = CHAR_W'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < density)
               pick = cfg_obstacle;
            else
               pick = cfg_empty;
            send_item(map_char(pick));
         end
         send_item(line_end());
      end
   endtask

   // ------------------------------------------------------------------
   // Scripted maps
   // ------------------------------------------------------------------
   typedef enum logic [1:0] {
      ROW_CELL,
      ROW_EOL,
      ROW_CSR
   } step_kind_type;

   typedef struct packed {
      step_kind_type    kind;
      logic [CNT_W-1:0] value;     // cell code, ignored line-end code, or register data
      csr_index_type    reg_sel;
      logic             typed;
      rsp_data_type     square;
   } script_row_type;

   localparam int SCRIPT_LEN = 27;

   script_row_type directed_rows [SCRIPT_LEN] = '{
      // lone free cell under the reset codes, one-row maps
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd0,    CSR_EMPTY_CHAR,    1'b1, '{10'd0, 10'd0, 11'd1, 1'b0}},
      // empty line
      '{ROW_EOL,  11'd255,  CSR_EMPTY_CHAR,    1'b1, '{10'd0, 10'd0, 11'd0, 1'b1}},
      // foreign code counts as free but flags the map
      '{ROW_CELL, 11'd120,  CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd85,   CSR_EMPTY_CHAR,    1'b1, '{10'd0, 10'd0, 11'd1, 1'b1}},
      // three rows: a 2x2 square, then a short last row
      '{ROW_CSR,  11'd3,    CSR_ROWS_IN_MAP,   1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd111,  CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd170,  CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd0,    CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd46,   CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd255,  CSR_EMPTY_CHAR,    1'b0, '0},
      // equal codes mean obstacle; zero rows act as one
      '{ROW_CSR,  11'd0,    CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CSR,  11'd0,    CSR_OBSTACLE_CHAR, 1'b0, '0},
      '{ROW_CSR,  11'd0,    CSR_ROWS_IN_MAP,   1'b0, '0},
      '{ROW_CELL, 11'd0,    CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd255,  CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd0,    CSR_EMPTY_CHAR,    1'b1, '{10'd0, 10'd1, 11'd1, 1'b1}},
      // extreme codes: 255 blocks, 0 is free
      '{ROW_CSR,  11'd255,  CSR_OBSTACLE_CHAR, 1'b0, '0},
      '{ROW_CELL, 11'd255,  CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_CELL, 11'd0,    CSR_EMPTY_CHAR,    1'b0, '0},
      '{ROW_EOL,  11'd170,  CSR_EMPTY_CHAR,    1'b1, '{10'd0, 10'd1, 11'd1, 1'b0}}
   };

   // ------------------------------------------------------------------
   // Request side: script, limit maps, then random maps
   // ------------------------------------------------------------------
   initial begin : stimulus
      int random_start;
      int maps_done;
      req_data_type item;
      logic [CNT_W-1:0] pick_rows;
      logic [CHAR_W-1:0] pick_empty;
      scan_reset();
      // hold reset, then release it for good
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the script; register rows wait for the block to go quiet
      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_CSR: begin
               wait_quiet();
               write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
            end
            default: begin
               item.mode     = (directed_rows[i].kind == ROW_EOL);
               item.cell_req = directed_rows[i].value[CHAR_W-1:0];
               transfer_item(item, directed_rows[i].typed, directed_rows[i].square);
            end
         endcase
      end

      // Row too wide: one row past MAX_WIDTH. This also fills every line
      // buffer entry, so later ragged rows never read an unwritten one.
      wait_quiet();
      write_reg(CSR_EMPTY_CHAR, CNT_W'(DOT));
      write_reg(CSR_OBSTACLE_CHAR, CNT_W'(RING));
      write_reg(CSR_ROWS_IN_MAP, 11'd1);
      for (int c = 0; c < WIDE_CELLS; c++)
         send_item(map_char(($urandom_range(0, 9) == 0) ? RING : DOT));
      send_item(line_end());

      // Tallest legal map, one column wide
      wait_quiet();
      write_reg(CSR_ROWS_IN_MAP, CNT_W'(MAX_HEIGHT));
      for (int r = 0; r < MAX_HEIGHT; r++) begin
         send_item(map_char(($urandom_range(0, 6) == 0) ? RING : DOT));
         send_item(line_end());
      end

      // Too many rows: empty lines, one free cell past row 1023 so the
      // reported row wraps; the width is learned late from that row
      wait_quiet();
      write_reg(CSR_ROWS_IN_MAP, CNT_W'(TALL_ROWS));
      for (int r = 0; r < TALL_ROWS; r++) begin
         if (r == WRAP_ROW)
            send_item(map_char(DOT));
         send_item(line_end());
      end

      // Random phases: fresh codes and height, then a few maps each
      random_start = items_sent;
      maps_done    = 0;
      while (items_sent - random_start < RANDOM_ITEMS || maps_done < RANDOM_MAPS) begin
         wait_quiet();
         pick_empty = CHAR_W'($urandom_range(0, 255));
         pick_rows  = ($urandom_range(0, 15) == 0) ? CNT_W'($urandom_range(0, 12))
                                                   : CNT_W'($urandom_range(1, 5));
         // upper data bits carry noise on the character registers
         write_reg(CSR_EMPTY_CHAR, {3'($urandom), pick_empty});
         write_reg(CSR_OBSTACLE_CHAR,
                   {3'($urandom), ($urandom_range(0, 9) == 0) ? pick_empty
                                                            : CHAR_W'($urandom_range(0, 255))});
         write_reg(CSR_ROWS_IN_MAP, pick_rows);
         repeat ($urandom_range(1, 4)) begin
            send_map((pick_rows == 0) ? 1 : int'(pick_rows));
            maps_done = maps_done + 1;
         end
      end

      // drain, then report
      wait_quiet();
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side: pop with random stalls, check against the oldest
   // expected square
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   initial begin : response_side
      int gap;
      rsp_data_type want;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap(pop_calm);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         // hold pop until a result transfers
         do @(posedge clock); while (rsp_empty);
         if (expected_squares.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d size %0d error %0d",
                     $time, rsp_data.best_row, rsp_data.best_col,
                     rsp_data.best_size, rsp_data.map_error);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_squares.pop_front();
            check_field("best_row",  want.best_row,  rsp_data.best_row);
            check_field("best_col",  want.best_col,  rsp_data.best_col);
            check_field("best_size", want.best_size, rsp_data.best_size);
            check_field("map_error", want.map_error, rsp_data.map_error);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d squares still expected", $time, expected_squares.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule

[sim.f]
sv/lesf_pkg.sv
sv/lesf_front.sv
sv/lesf_queue.sv
sv/lesf_back.sv
sv/largest_empty_square_finder_unit.sv
sim/largest_empty_square_finder_unit_tb.sv
